[src/bmgq_pkg.sv]
// Shared constants, register codes and sequencer states of the box-mean glyph quantizer.
package bmgq_pkg;

    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_EXTENT_DEF = 7;
    localparam int ROW_LIMIT      = 256;
    localparam int LUMA_FULL      = 255;
    localparam int RW             = 9;
    localparam int CFG_DW         = 9;
    localparam int CFG_IW         = 2;

    localparam logic [CFG_IW-1:0] CFG_FRAME_WIDTH   = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_FRAME_HEIGHT  = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_WINDOW_EXTENT = 2'd2;
    localparam logic [CFG_IW-1:0] CFG_TOP_LEVEL     = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LAST,
        ST_DIV,
        ST_OUT
    } seq_state_t;

endpackage

[src/box_mean_glyph_quantizer.sv]
// Top level of the box-mean glyph quantizer: position tracking, sequencer and datapath.
// Each request writes its pixel when it is accepted; a request that completes no window is done then.
// Each result is paced by the single read port of the line store and by the
// bit-serial divider; a burst serialises.
// A new request is taken only after every result of the previous one has been delivered.
// Reset is asynchronous: counters and configuration return to their defaults at once;
// the line store is not cleared and needs no clearing pass.
module box_mean_glyph_quantizer
    import bmgq_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_EXTENT = MAX_EXTENT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        pixel,
    input  logic              frame_start,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        out_row,
    output logic [7:0]        out_col,
    output logic [3:0]        glyph_level,
    output logic              last
);

    // The line store keeps one row slot for every row the window can span.
    localparam int SLOTS = MAX_EXTENT + 1;
    localparam int SW    = $clog2(SLOTS);
    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int AW    = $clog2(SLOTS * MAX_WIDTH);
    localparam int EW    = $clog2(MAX_EXTENT + 2);
    localparam int CNT_W = $clog2(SLOTS * SLOTS + 1);
    localparam int SUM_W = $clog2(SLOTS * SLOTS * LUMA_FULL + 1);

    // Configuration registers.
    logic [8:0] width_reg;
    logic [8:0] height_reg;
    logic [2:0] extent_reg;
    logic [3:0] top_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
            extent_reg <= 3'd4;
            top_reg    <= 4'd9;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_FRAME_WIDTH:   width_reg  <= cfg_data;
                CFG_FRAME_HEIGHT:  height_reg <= cfg_data;
                CFG_WINDOW_EXTENT: extent_reg <= cfg_data[2:0];
                CFG_TOP_LEVEL:     top_reg    <= cfg_data[3:0];
                default:           ;
            endcase
        end
    end

    // Effective frame geometry: zero counts as one, and values are saturated.
    logic [CW-1:0] w_eff;
    logic [RW-1:0] h_eff;
    logic [EW-1:0] e_eff;

    always_comb
    begin
        if (width_reg == 9'd0)
            w_eff = CW'(1);
        else if (int'(width_reg) > MAX_WIDTH)
            w_eff = CW'(MAX_WIDTH);
        else
            w_eff = CW'(width_reg);

        if (height_reg == 9'd0)
            h_eff = RW'(1);
        else if (int'(height_reg) > ROW_LIMIT)
            h_eff = RW'(ROW_LIMIT);
        else
            h_eff = height_reg;

        if (int'(extent_reg) > MAX_EXTENT)
            e_eff = EW'(MAX_EXTENT);
        else
            e_eff = EW'(extent_reg);
    end

    seq_state_t state_reg;
    seq_state_t state_next;

    // Raster position carried between requests, with the slot of the current row.
    logic [RW-1:0] row_reg;
    logic [CW-1:0] col_reg;
    logic [SW-1:0] slot_reg;
    logic          pend_reg;

    // Position of the request being worked on and its range of anchors.
    logic [RW-1:0] cur_row_reg;
    logic [CW-1:0] cur_col_reg;
    logic [SW-1:0] cur_slot_reg;
    logic [RW-1:0] r1_reg;
    logic [CW-1:0] c0_reg;
    logic [CW-1:0] c1_reg;
    logic [RW-1:0] ar_reg;
    logic [CW-1:0] ac_reg;
    logic [RW-1:0] y_reg;
    logic [CW-1:0] x_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [7:0]    row_out_reg;
    logic [7:0]    col_out_reg;
    logic [3:0]    glyph_reg;
    logic          last_reg;

    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
        slot_inc = (s == SW'(SLOTS - 1)) ? '0 : s + SW'(1);
    endfunction

    // Position of the incoming pixel, the position after it and its anchor range.
    logic [RW-1:0] ra;
    logic [CW-1:0] ca;
    logic [SW-1:0] sa;
    logic [RW-1:0] rn;
    logic [CW-1:0] cn;
    logic [SW-1:0] sn;
    logic [RW-1:0] r0;
    logic [RW-1:0] r1;
    logic [CW-1:0] c0;
    logic [CW-1:0] c1;
    logic          any_r;
    logic          any_c;
    logic [RW-1:0] e_row;
    logic [CW-1:0] e_col;

    always_comb
    begin
        e_row = RW'(e_eff);
        e_col = CW'(e_eff);
        ra = row_reg;
        ca = col_reg;
        sa = slot_reg;
        if (frame_start)
        begin
            ra = '0;
            ca = '0;
            sa = '0;
        end
        // A position beyond a shrunk frame wraps before the pixel is stored.
        if (ca >= w_eff)
        begin
            ca = '0;
            ra = ra + RW'(1);
            sa = slot_inc(sa);
        end
        if (ra >= h_eff)
        begin
            ra = '0;
            sa = '0;
        end

        cn = ca + CW'(1);
        rn = ra;
        sn = sa;
        if (cn >= w_eff)
        begin
            cn = '0;
            rn = ra + RW'(1);
            sn = slot_inc(sa);
            if (rn >= h_eff)
            begin
                rn = '0;
                sn = '0;
            end
        end

        // On the bottom row every pending anchor row closes; elsewhere at most one.
        any_r = 1'b1;
        r1 = ra;
        r0 = (ra >= e_row) ? ra - e_row : '0;
        if (ra != h_eff - RW'(1))
        begin
            if (ra >= e_row)
                r1 = ra - e_row;
            else
                any_r = 1'b0;
        end

        any_c = 1'b1;
        c1 = ca;
        c0 = (ca >= e_col) ? ca - e_col : '0;
        if (ca != w_eff - CW'(1))
        begin
            if (ca >= e_col)
                c1 = ca - e_col;
            else
                any_c = 1'b0;
        end
    end

    // Line store addressing: the slot of a window row counts back from the current slot.
    logic          accept;
    logic          rd_en;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic [7:0]    rdata;
    logic [EW-1:0] back;
    logic [SW:0]   slot_y;

    always_comb
    begin
        back = EW'(cur_row_reg - y_reg);
        if ({1'b0, cur_slot_reg} >= (SW+1)'(back))
            slot_y = {1'b0, cur_slot_reg} - (SW+1)'(back);
        else
            slot_y = {1'b0, cur_slot_reg} + (SW+1)'(SLOTS) - (SW+1)'(back);
        raddr = AW'(AW'(slot_y) * AW'(MAX_WIDTH) + AW'(x_reg));
        waddr = AW'(AW'(sa) * AW'(MAX_WIDTH) + AW'(ca));
    end

    bmgq_line_mem #(
        .DEPTH (SLOTS * MAX_WIDTH),
        .AW    (AW)
    ) u_line_mem (
        .clk   (clk),
        .we    (accept),
        .waddr (waddr),
        .wdata (pixel),
        .re    (rd_en),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Mean of the window: the final sample joins the sum as the divider starts.
    logic             div_start;
    logic             div_done;
    logic [7:0]       mean;
    logic [EW-1:0]    span_r;
    logic [EW-1:0]    span_c;
    logic [CNT_W-1:0] count;
    logic [SUM_W-1:0] sum_total;

    always_comb
    begin
        span_r    = EW'(cur_row_reg - ar_reg + RW'(1));
        span_c    = EW'(cur_col_reg - ac_reg + CW'(1));
        count     = CNT_W'(CNT_W'(span_r) * CNT_W'(span_c));
        sum_total = sum_reg + SUM_W'(rdata);
    end

    bmgq_divider #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W),
        .QUO_W (8)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (sum_total),
        .denom    (count),
        .done     (div_done),
        .quotient (mean)
    );

    // Level = top * mean / 255; for products below 65535 the quotient by 255 is
    // (p + 1 + p / 256) / 256.
    logic [11:0] product;
    logic [12:0] q_sum;
    logic [3:0]  level;

    always_comb
    begin
        product = 12'(top_reg) * 12'(mean);
        q_sum   = 13'(product) + 13'd1 + 13'(product[11:8]);
        level   = q_sum[11:8];
    end

    // Sequencer.
    logic read_last;
    logic anchor_last;

    assign read_last   = (y_reg == cur_row_reg) && (x_reg == cur_col_reg);
    assign anchor_last = (ar_reg == r1_reg) && (ac_reg == c1_reg);
    assign accept      = (state_reg == ST_IDLE) && in_valid;

    always_comb
    begin
        state_next = state_reg;
        in_stall   = (state_reg != ST_IDLE);
        out_valid  = (state_reg == ST_OUT);
        rd_en      = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && any_r && any_c)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                rd_en = 1'b1;
                if (read_last)
                    state_next = ST_LAST;
            end
            ST_LAST:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_stall)
                    state_next = last_reg ? ST_IDLE : ST_READ;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            slot_reg  <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= rd_en;
            if (accept)
            begin
                row_reg  <= rn;
                col_reg  <= cn;
                slot_reg <= sn;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cur_row_reg  <= ra;
                    cur_col_reg  <= ca;
                    cur_slot_reg <= sa;
                    r1_reg       <= r1;
                    c0_reg       <= c0;
                    c1_reg       <= c1;
                    ar_reg       <= r0;
                    ac_reg       <= c0;
                    y_reg        <= r0;
                    x_reg        <= c0;
                    sum_reg      <= '0;
                end
            end
            ST_READ:
            begin
                if (pend_reg)
                    sum_reg <= sum_total;
                if (x_reg == cur_col_reg)
                begin
                    x_reg <= ac_reg;
                    y_reg <= y_reg + RW'(1);
                end
                else
                begin
                    x_reg <= x_reg + CW'(1);
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    glyph_reg   <= level;
                    row_out_reg <= ar_reg[7:0];
                    col_out_reg <= 8'(ac_reg);
                    last_reg    <= anchor_last;
                end
            end
            ST_OUT:
            begin
                if (!out_stall && !last_reg)
                begin
                    sum_reg <= '0;
                    if (ac_reg == c1_reg)
                    begin
                        ac_reg <= c0_reg;
                        ar_reg <= ar_reg + RW'(1);
                        y_reg  <= ar_reg + RW'(1);
                        x_reg  <= c0_reg;
                    end
                    else
                    begin
                        ac_reg <= ac_reg + CW'(1);
                        y_reg  <= ar_reg;
                        x_reg  <= ac_reg + CW'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_row     = row_out_reg;
    assign out_col     = col_out_reg;
    assign glyph_level = glyph_reg;
    assign last        = last_reg;

`ifndef SYNTHESIS
    // Delivering the final result of a request frees the input side.
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && last_reg) |=> !in_stall)
        else $error("input still stalled after final result");

    // The divider only finishes while the sequencer waits for it.
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside its wait state");

    // Window reads never run past the row of the current pixel.
    a_read_rows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (y_reg <= cur_row_reg))
        else $error("window read beyond current row");
`endif

endmodule

[src/bmgq_line_mem.sv]
// Line store: one write port and one registered read port.
module bmgq_line_mem #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/bmgq_divider.sv]
// Restoring divider producing one quotient bit per cycle.
module bmgq_divider #(
    parameter int NUM_W = 14,
    parameter int DEN_W = 7,
    parameter int QUO_W = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output logic             done,
    output logic [QUO_W-1:0] quotient
);

    localparam int KW = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [KW-1:0]    step_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W:0]   trial;
    logic             take;

    always_comb
    begin
        trial = {rem_reg, quo_reg[NUM_W-1]};
        take  = (trial >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (step_reg == KW'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                step_reg <= step_reg + KW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            den_reg <= denom;
            quo_reg <= numer;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? DEN_W'(trial - {1'b0, den_reg}) : DEN_W'(trial);
            quo_reg <= {quo_reg[NUM_W-2:0], take};
        end
    end

    assign done     = done_reg;
    assign quotient = QUO_W'(quo_reg);

endmodule
